[rtl/core/fwms_pkg.sv]
// ----------------------------------------------------------------------------
// fwms_pkg
// Types, codes and default sizes shared by the four-way merge selector.
// ----------------------------------------------------------------------------
package fwms_pkg;

	localparam int VALUE_W            = 32;
	localparam int LANE_FIELD_W       = 2;
	localparam int LANES_DEFAULT      = 4;
	localparam int LANE_DEPTH_DEFAULT = 256;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                        operation;
		logic [LANE_FIELD_W-1:0]    lane;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  result_value;
		logic [LANE_FIELD_W-1:0]    source_lane;
	} rsp_t;

	// Per-lane command from the top level
	typedef struct packed {
		logic                       push;
		logic                       pop;
		logic signed [VALUE_W-1:0]  value;
	} lane_ctl_t;

	// Per-lane status toward the selector and the top level
	typedef struct packed {
		logic                       nonempty;
		logic                       full;
		logic signed [VALUE_W-1:0]  head;
	} lane_stat_t;

endpackage

[rtl/core/fwms_ram.sv]
// ----------------------------------------------------------------------------
// fwms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fwms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/fwms_lane.sv]
// ----------------------------------------------------------------------------
// fwms_lane
// One sorted input lane: buffer RAM, read and fill counters, and a two-entry
// head cache fed from the RAM so that a pop can follow a pop every cycle.
// ----------------------------------------------------------------------------
module fwms_lane import fwms_pkg::*; #(
	parameter int LANE_DEPTH = LANE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctl_t  ctl,
	output lane_stat_t stat
);

	localparam int ADDR_W = $clog2(LANE_DEPTH);
	localparam int CNT_W  = $clog2(LANE_DEPTH + 1);
	localparam int PTR_W  = CNT_W + 1;

	logic [CNT_W-1:0]          rd_q, fill_q, rd_d, fill_d, rd_inc;
	logic [PTR_W-1:0]          fetch_ptr;
	logic [ADDR_W-1:0]         raddr;
	logic [VALUE_W-1:0]        ram_rdata;
	logic signed [VALUE_W-1:0] head_q, next_q, head_d, next_d, fetched, fwd_data_q;
	logic                      fwd_q, fwd_d;

	fwms_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(LANE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(VALUE_W'($unsigned(ctl.value))),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Element two past the head; take the pushed value if it was written
	// at the same edge the RAM read was issued
	assign fetched = fwd_q ? fwd_data_q : $signed(ram_rdata);

	always_comb begin
		rd_inc = rd_q + 1'b1;
		rd_d   = rd_q;
		fill_d = fill_q;
		head_d = head_q;
		next_d = next_q;
		if (ctl.pop) begin
			head_d = next_q;
			next_d = fetched;
			if (rd_inc == fill_q) begin
				// drained: free the whole buffer
				rd_d   = '0;
				fill_d = '0;
			end else begin
				rd_d = rd_inc;
			end
		end else if (ctl.push) begin
			fill_d = fill_q + 1'b1;
			if (fill_q == rd_q) begin
				head_d = ctl.value;
			end
			if (fill_q == rd_inc) begin
				next_d = ctl.value;
			end
		end
		fetch_ptr = PTR_W'(rd_d) + PTR_W'(2);
		raddr     = (fetch_ptr < PTR_W'(LANE_DEPTH)) ? fetch_ptr[ADDR_W-1:0] : '0;
		fwd_d     = ctl.push && (PTR_W'(fill_q) == fetch_ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			fill_q <= '0;
			fwd_q  <= 1'b0;
		end else begin
			rd_q   <= rd_d;
			fill_q <= fill_d;
			fwd_q  <= fwd_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q     <= head_d;
		next_q     <= next_d;
		fwd_data_q <= ctl.value;
	end

	assign stat.nonempty = (rd_q != fill_q);
	assign stat.full     = (fill_q == CNT_W'(LANE_DEPTH));
	assign stat.head     = head_q;

	a_rd_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= fill_q)
		else $error("lane read index passed fill count");

	a_push_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full && !ctl.pop)
		else $error("push to a full lane or together with a pop");

endmodule

[rtl/core/fwms_select.sv]
// ----------------------------------------------------------------------------
// fwms_select
// Picks the smallest head among the non-empty lanes with a compare tree;
// on equal values the lower lane wins.
// ----------------------------------------------------------------------------
module fwms_select import fwms_pkg::*; #(
	parameter int LANES = LANES_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_stat_t [LANES-1:0]     stat,
	output logic                       win_valid,
	output logic [$clog2(LANES)-1:0]   win_lane,
	output logic signed [VALUE_W-1:0]  win_value
);

	localparam int IDX_W = $clog2(LANES);
	localparam int LEAFS = 1 << IDX_W;
	localparam int NODES = 2 * LEAFS - 1;

	logic                      nv   [NODES];
	logic signed [VALUE_W-1:0] nval [NODES];
	logic [IDX_W-1:0]          nidx [NODES];

	for (genvar i = 0; i < LEAFS; i++) begin : g_leaf
		if (i < LANES) begin : g_used
			assign nv[LEAFS-1+i]   = stat[i].nonempty;
			assign nval[LEAFS-1+i] = stat[i].head;
		end else begin : g_pad
			assign nv[LEAFS-1+i]   = 1'b0;
			assign nval[LEAFS-1+i] = '0;
		end
		assign nidx[LEAFS-1+i] = IDX_W'(i);
	end

	// Left child always holds the lower lane numbers, so it wins ties
	for (genvar k = 0; k < LEAFS - 1; k++) begin : g_node
		logic take_left;
		assign take_left = nv[2*k+1] && (!nv[2*k+2] || (nval[2*k+1] <= nval[2*k+2]));
		assign nv[k]     = nv[2*k+1] || nv[2*k+2];
		assign nval[k]   = take_left ? nval[2*k+1] : nval[2*k+2];
		assign nidx[k]   = take_left ? nidx[2*k+1] : nidx[2*k+2];
	end

	assign win_valid = nv[0];
	assign win_lane  = nidx[0];
	assign win_value = nval[0];

	a_win_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> stat[win_lane].nonempty && (stat[win_lane].head == win_value))
		else $error("selected lane is empty or head mismatch");

endmodule

[rtl/core/four_way_merge_select.sv]
// ----------------------------------------------------------------------------
// four_way_merge_select
// Merge stage of an external sort: push values into sorted lanes, pop the
// smallest head across all lanes.
// ----------------------------------------------------------------------------
// One push or pop is taken every cycle unless rsp_ready stalls the output, and
// each gives exactly one result (input register, then result register). The
// rate is set by each lane's head cache: the two front elements of a lane sit
// in registers and the lane RAM's single read port prefetches the third, so
// back-to-back pops from the same lane need no wait. A lane frees its buffer
// only when a pop drains it; a push to a full lane is rejected. No clearing
// pass runs after reset: items are taken from the first cycle.
// ----------------------------------------------------------------------------
module four_way_merge_select import fwms_pkg::*; #(
	parameter int LANES      = LANES_DEFAULT,
	parameter int LANE_DEPTH = LANE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(LANES);

	req_t                      req_s1;
	logic                      valid_s1;
	logic                      advance;
	rsp_t                      rsp_q, rsp_d;
	logic                      rsp_valid_q;
	lane_ctl_t  [LANES-1:0]    ctl;
	lane_stat_t [LANES-1:0]    stat;
	logic       [LANES-1:0]    lane_hit, lane_act;
	logic                      lane_known, lane_full;
	logic                      win_valid;
	logic [IDX_W-1:0]          win_lane;
	logic signed [VALUE_W-1:0] win_value;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign lane_hit[i]  = (32'(req_s1.lane) == 32'(i));
		assign ctl[i].push  = advance && (req_s1.operation == OP_PUSH) && lane_hit[i]
			&& !stat[i].full;
		assign ctl[i].pop   = advance && (req_s1.operation == OP_POP) && win_valid
			&& (win_lane == IDX_W'(i));
		assign ctl[i].value = req_s1.value;
		assign lane_act[i]  = ctl[i].push || ctl[i].pop;

		fwms_lane #(
			.LANE_DEPTH(LANE_DEPTH)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl[i]),
			.stat  (stat[i])
		);
	end

	fwms_select #(
		.LANES(LANES)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.win_valid(win_valid),
		.win_lane (win_lane),
		.win_value(win_value)
	);

	function automatic logic [LANES-1:0] full_vec(input lane_stat_t [LANES-1:0] s);
		logic [LANES-1:0] f;
		for (int j = 0; j < LANES; j++) begin
			f[j] = s[j].full;
		end
		return f;
	endfunction

	assign lane_known = |lane_hit;
	assign lane_full  = |(lane_hit & full_vec(stat));

	always_comb begin
		rsp_d.status       = ST_OK;
		rsp_d.result_value = '0;
		rsp_d.source_lane  = '0;
		if (req_s1.operation == OP_PUSH) begin
			// reject lanes without hardware as well as full ones
			if (!lane_known || lane_full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (win_valid) begin
			rsp_d.result_value = win_value;
			rsp_d.source_lane  = LANE_FIELD_W'(win_lane);
		end else begin
			rsp_d.status = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_act))
		else $error("more than one lane updated by one item");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("processed item produced no result");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stalled item lost from input register");

endmodule
